/* rtl/core/sfp_pkg.sv */
// Shared types and constants for the sensor frame parser with XOR check.
package sfp_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_HDR  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_STAT = POS_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;

    localparam logic [7:0] HEADER_RESET = 8'h16;
    localparam logic [7:0] LENGTH_RESET = 8'd32;

    typedef enum logic [1:0] {
        VERDICT_OK         = 2'd0,
        VERDICT_BAD_HEADER = 2'd1,
        VERDICT_BAD_SUM    = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        OP_STATUS  = 2'd0,
        OP_WORD    = 2'd1,
        OP_VERDICT = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } in_t;

    typedef struct packed {
        logic [3:0]  field_index;
        logic [15:0] field_value;
        logic        is_verdict;
        logic [1:0]  verdict_code;
    } out_t;

    // Classified work passed from the front to the back.
    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] index;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] xor_sum;
        logic       hdr_bad;
    } op_t;

endpackage

/* rtl/core/sfp_front.sv */
// Front end: byte tracking, running XOR, header checks and classification.
module sfp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  sfp_pkg::in_t                  item,
    input  logic                          cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          op_full,
    output logic                          op_push,
    output sfp_pkg::op_t                  op
);

    logic [sfp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                xor_reg, xor_next;
    logic [7:0]                hb_reg, hb_next;
    logic                      bad_reg, bad_next;
    logic [7:0]                hdr_reg, len_reg;

    logic [sfp_pkg::POS_W-1:0] eff_pos;
    logic [7:0]                eff_xor;
    logic [7:0]                eff_hb;
    logic                      eff_bad;

    always_comb
    begin
        // frame_start restarts the frame before the byte is looked at
        eff_pos = item.frame_start ? '0 : pos_reg;
        eff_xor = item.frame_start ? 8'd0 : xor_reg;
        eff_hb  = item.frame_start ? 8'd0 : hb_reg;
        eff_bad = item.frame_start ? 1'b0 : bad_reg;

        pos_next   = pos_reg;
        xor_next   = xor_reg;
        hb_next    = hb_reg;
        bad_next   = bad_reg;
        op_push    = 1'b0;
        op.kind    = sfp_pkg::OP_STATUS;
        op.index   = 4'd0;
        op.hi      = eff_hb;
        op.lo      = item.byte_value;
        op.xor_sum = eff_xor;
        op.hdr_bad = eff_bad;

        if (accept)
        begin
            pos_next = eff_pos;
            xor_next = eff_xor;
            hb_next  = eff_hb;
            bad_next = eff_bad;
            if (eff_pos >= sfp_pkg::POS_IDLE)
            begin
                // idle: byte dropped
            end
            else if (eff_pos == sfp_pkg::POS_LAST)
            begin
                pos_next = sfp_pkg::POS_IDLE;
                op_push  = 1'b1;
                op.kind  = sfp_pkg::OP_VERDICT;
            end
            else
            begin
                xor_next = eff_xor ^ item.byte_value;
                pos_next = eff_pos + 1'b1;
                if (eff_pos == sfp_pkg::POS_HDR)
                begin
                    bad_next = eff_bad | (item.byte_value != hdr_reg);
                end
                else if (eff_pos == sfp_pkg::POS_LEN)
                begin
                    bad_next = eff_bad | (item.byte_value != len_reg);
                end
                else if (eff_pos == sfp_pkg::POS_STAT)
                begin
                    op_push = 1'b1;
                    op.kind = sfp_pkg::OP_STATUS;
                end
                else if (eff_pos[0])
                begin
                    hb_next = item.byte_value;
                end
                else
                begin
                    op_push  = 1'b1;
                    op.kind  = sfp_pkg::OP_WORD;
                    op.index = 4'(eff_pos[4:1] - 4'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= sfp_pkg::POS_IDLE;
            xor_reg <= 8'd0;
            hb_reg  <= 8'd0;
            bad_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
            hb_reg  <= hb_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= sfp_pkg::HEADER_RESET;
            len_reg <= sfp_pkg::LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sfp_pkg::CFG_HEADER)
            begin
                hdr_reg <= cfg_data;
            end
            else if (cfg_index == sfp_pkg::CFG_LENGTH)
            begin
                len_reg <= cfg_data;
            end
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sfp_pkg::POS_IDLE)
        else $error("byte position out of range");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.frame_start |=> pos_reg == sfp_pkg::POS_LEN)
        else $error("frame start did not restart at byte 0");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> !op_full)
        else $error("op pushed into full queue");

endmodule

/* rtl/core/sfp_opq.sv */
// Two-entry queue of classified ops between front and back.
module sfp_opq (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  sfp_pkg::op_t op_in,
    output logic         full,
    input  logic         pop,
    output sfp_pkg::op_t op_out,
    output logic         empty
);

    sfp_pkg::op_t mem [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign op_out = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("op queue count overflow");

endmodule

/* rtl/core/sfp_back.sv */
// Back end: turns ops into result beats and holds them for the consumer.
module sfp_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_empty,
    input  sfp_pkg::op_t op,
    output logic         op_pop,
    output sfp_pkg::out_t result,
    output logic         empty,
    input  logic         pop
);

    sfp_pkg::out_t buf_q [2];
    sfp_pkg::out_t res_next;
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       out_pop;

    assign empty   = (cnt_reg == 2'd0);
    assign out_pop = pop && !empty;
    assign op_pop  = !op_empty && (cnt_reg != 2'd2);
    assign result  = buf_q[rd_reg];

    always_comb
    begin
        res_next = '0;
        unique case (op.kind)
            sfp_pkg::OP_STATUS:
            begin
                res_next.field_value = {8'd0, op.lo};
            end
            sfp_pkg::OP_WORD:
            begin
                res_next.field_index = op.index;
                res_next.field_value = {op.hi, op.lo};
            end
            sfp_pkg::OP_VERDICT:
            begin
                res_next.is_verdict = 1'b1;
                // header fault wins over checksum mismatch
                if (op.hdr_bad)
                begin
                    res_next.verdict_code = sfp_pkg::VERDICT_BAD_HEADER;
                end
                else if (op.lo != op.xor_sum)
                begin
                    res_next.verdict_code = sfp_pkg::VERDICT_BAD_SUM;
                end
                else
                begin
                    res_next.verdict_code = sfp_pkg::VERDICT_OK;
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            buf_q[wr_reg] <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (op_pop)
            begin
                wr_reg <= ~wr_reg;
            end
            if (out_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, op_pop} - {1'b0, out_pop};
        end
    end

    a_buf_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result buffer count overflow");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.is_verdict |-> result.field_index == 4'd0
            && result.field_value == 16'd0)
        else $error("verdict beat carries field data");

endmodule

/* rtl/core/sensor_frame_parser_xor_check.sv */
// Top level: sensor frame parser with XOR checksum.
//
// Input channel is a queue write side: a byte beat (byte_value, frame_start)
// is taken at a clock edge with push high and full low. frame_start marks
// byte 0 and always restarts the frame. Results come out of a queue read
// side: the oldest result sits on result while empty is low and is taken
// when pop is high. Bytes 2..30 produce the status field and fourteen
// big-endian words (one beat per low byte); byte 31 produces a verdict beat.
// Bytes 0, 1, word high bytes and bytes outside a frame produce nothing.
// Config: cfg_index 0 = expected header, 1 = expected length; other
// indexes are dropped. cfg_ready is always high.
// Throughput: one byte per cycle while full is low.
// On its way a result is held first in the op queue, written at the edge that
// takes its byte; the back stage then moves it into the result buffer when
// that buffer has room.
// Reset clears the position to idle and empties both queues; the config
// registers return to 0x16 and 32. When pop is held low, the result buffer
// and the op queue fill (two beats each), then full rises.
module sensor_frame_parser_xor_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sfp_pkg::in_t                  item,
    output logic                          empty,
    input  logic                          pop,
    output sfp_pkg::out_t                 result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    logic         accept;
    logic         op_push, op_full, op_pop, op_empty;
    sfp_pkg::op_t op_in, op_out;

    assign cfg_ready = 1'b1;
    assign full      = op_full;
    assign accept    = push && !op_full;

    sfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_full   (op_full),
        .op_push   (op_push),
        .op        (op_in)
    );

    sfp_opq u_opq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (op_push),
        .op_in  (op_in),
        .full   (op_full),
        .pop    (op_pop),
        .op_out (op_out),
        .empty  (op_empty)
    );

    sfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op       (op_out),
        .op_pop   (op_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

/* verif/testbench.sv */
// Testbench for the sensor frame parser: random frames checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_GAP      = 13;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BYTES  = 220;
    localparam int NUM_PHASES   = 5;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT_A    = 60;
    localparam int HOLD_AT_B    = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE       = 4;
    localparam int DRAIN        = 8;

    // Spare register indexes; the block drops writes to these.
    localparam logic [sfp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sfp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HEADER,
        FR_BAD_LENGTH,
        FR_BAD_SUM,
        FR_CUT,
        FR_EDGE
    } frame_kind_t;

    class frame_scoreboard;
        logic [7:0]                hdr_want;
        logic [7:0]                len_want;
        logic [sfp_pkg::POS_W-1:0] pos;
        logic [7:0]                xsum;
        logic [7:0]                hi;
        logic                      hdr_bad;
        sfp_pkg::out_t             fields_due[$];
        int                        errors;

        function new();
            hdr_want = sfp_pkg::HEADER_RESET;
            len_want = sfp_pkg::LENGTH_RESET;
            pos      = sfp_pkg::POS_IDLE;
            xsum     = '0;
            hi       = '0;
            hdr_bad  = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [sfp_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == sfp_pkg::CFG_HEADER)
                hdr_want = data;
            else if (idx == sfp_pkg::CFG_LENGTH)
                len_want = data;
        endfunction

        function int pending();
            return fields_due.size();
        endfunction

        // Advance the parser state by one accepted byte beat.
        function void note_byte(sfp_pkg::in_t it);
            sfp_pkg::out_t             r;
            logic [sfp_pkg::POS_W-1:0] p;
            sfp_pkg::verdict_t         code;
            r = '0;
            if (it.frame_start)
            begin
                pos     = sfp_pkg::POS_HDR;
                xsum    = '0;
                hi      = '0;
                hdr_bad = 1'b0;
            end
            p = pos;
            if (p >= sfp_pkg::POS_IDLE)
                return;
            if (p == sfp_pkg::POS_LAST)
            begin
                if (hdr_bad)
                    code = sfp_pkg::VERDICT_BAD_HEADER;
                else if (it.byte_value != xsum)
                    code = sfp_pkg::VERDICT_BAD_SUM;
                else
                    code = sfp_pkg::VERDICT_OK;
                pos            = sfp_pkg::POS_IDLE;
                r.is_verdict   = 1'b1;
                r.verdict_code = code;
                fields_due.push_back(r);
                return;
            end
            xsum = xsum ^ it.byte_value;
            pos  = p + 1'b1;
            if (p == sfp_pkg::POS_HDR)
            begin
                if (it.byte_value != hdr_want)
                    hdr_bad = 1'b1;
            end
            else if (p == sfp_pkg::POS_LEN)
            begin
                if (it.byte_value != len_want)
                    hdr_bad = 1'b1;
            end
            else if (p == sfp_pkg::POS_STAT)
            begin
                r.field_value = {8'h00, it.byte_value};
                fields_due.push_back(r);
            end
            else if (p[0])
            begin
                hi = it.byte_value;
            end
            else
            begin
                r.field_index = 4'((p - sfp_pkg::POS_STAT) >> 1);
                r.field_value = {hi, it.byte_value};
                fields_due.push_back(r);
            end
        endfunction

        function void check_result(sfp_pkg::out_t got);
            sfp_pkg::out_t want;
            if (fields_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected beat: idx=%0d val=%h verdict=%b code=%0d",
                             got.field_index, got.field_value, got.is_verdict,
                             got.verdict_code);
                return;
            end
            want = fields_due.pop_front();
            if (got.field_index !== want.field_index || got.field_value !== want.field_value
                || got.is_verdict !== want.is_verdict
                || got.verdict_code !== want.verdict_code)
            begin
                errors++;
                // fields in order: index, value, verdict flag, verdict code
                if (errors <= MAX_REPORTS)
                    $display("mismatch: got %0d %h %b %0d, expected %0d %h %b %0d",
                             got.field_index, got.field_value, got.is_verdict,
                             got.verdict_code, want.field_index, want.field_value,
                             want.is_verdict, want.verdict_code);
            end
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    sfp_pkg::in_t                  item      = '0;
    logic                          empty;
    logic                          pop       = 1'b0;
    sfp_pkg::out_t                 result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = '0;

    frame_scoreboard sb;
    logic [7:0]      hdr_cfg     = sfp_pkg::HEADER_RESET;
    logic [7:0]      len_cfg     = sfp_pkg::LENGTH_RESET;
    logic            send_burst  = 1'b0;
    logic            recv_burst  = 1'b0;
    int              frame_bytes = 0;
    int              quiet       = 0;

    sensor_frame_parser_xor_check i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Handshake monitor: everything sampled with pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.note_byte(item);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random pop gaps, two long hold-offs to back up the block.
    initial
    begin
        int gap;
        int beats;
        beats = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (beats % 32 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            if (beats == HOLD_AT_A || beats == HOLD_AT_B)
                gap = HOLD_CYCLES;
            else
                gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            beats++;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{byte_value: b, frame_start: s};
        do @(posedge clk); while (full);
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] fb[sfp_pkg::FRAME_BYTES];
        logic [7:0] x;
        int         n;
        send_burst = ($urandom_range(0, 3) == 0);
        fb[0] = hdr_cfg;
        fb[1] = len_cfg;
        for (int i = 2; i < sfp_pkg::FRAME_BYTES - 1; i++)
            fb[i] = (kind == FR_EDGE) ? (((i & 2) != 0) ? 8'hFF : 8'h00) : rand_byte();
        if (kind == FR_BAD_HEADER)
            fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
        if (kind == FR_BAD_LENGTH)
            fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
        x = '0;
        for (int i = 0; i < sfp_pkg::FRAME_BYTES - 1; i++)
            x = x ^ fb[i];
        fb[sfp_pkg::FRAME_BYTES-1] = x;
        // bad header with a bad sum too checks that the header fault wins
        if (kind == FR_BAD_SUM
            || ((kind == FR_BAD_HEADER || kind == FR_BAD_LENGTH) && $urandom_range(0, 1) == 1))
            fb[sfp_pkg::FRAME_BYTES-1] = x ^ 8'($urandom_range(1, 255));
        n = (kind == FR_CUT) ? $urandom_range(1, sfp_pkg::FRAME_BYTES - 1)
                             : sfp_pkg::FRAME_BYTES;
        for (int i = 0; i < n; i++)
        begin
            send_byte(fb[i], i == 0);
            frame_bytes++;
        end
        // trailing bytes past the checksum are dropped by the block
        if (kind != FR_CUT && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0);
    endtask

    task automatic write_reg(input logic [sfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] data);
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sfp_pkg::CFG_HEADER)
            hdr_cfg = data;
        else if (idx == sfp_pkg::CFG_LENGTH)
            len_cfg = data;
    endtask

    initial
    begin
        int pick;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(sfp_pkg::CFG_HEADER, 8'h00);
                    write_reg(sfp_pkg::CFG_LENGTH, 8'hFF);
                end
                2:
                begin
                    write_reg(sfp_pkg::CFG_HEADER, 8'hFF);
                    write_reg(sfp_pkg::CFG_LENGTH, 8'h00);
                end
                3:
                begin
                    write_reg(sfp_pkg::CFG_HEADER, 8'($urandom));
                    write_reg(CFG_SPARE_A, 8'($urandom));
                    write_reg(sfp_pkg::CFG_LENGTH, 8'($urandom));
                    write_reg(CFG_SPARE_B, 8'($urandom));
                end
                4:
                begin
                    write_reg(sfp_pkg::CFG_HEADER, sfp_pkg::HEADER_RESET);
                    write_reg(sfp_pkg::CFG_LENGTH, sfp_pkg::LENGTH_RESET);
                end
                default:
                begin
                end
            endcase

            if (phase == 0)
            begin
                // bytes before any start, then a frame cut short by a restart
                send_byte(8'h00, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(hdr_cfg, 1'b1);
                send_byte(len_cfg, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_frame(FR_EDGE);
                send_byte(8'hA5, 1'b0);
            end

            while (frame_bytes < (phase + 1) * PHASE_BYTES)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    send_frame(FR_GOOD);
                else if (pick == 12)
                    send_frame(FR_BAD_HEADER);
                else if (pick == 13)
                    send_frame(FR_BAD_LENGTH);
                else if (pick == 14)
                    send_frame(FR_BAD_SUM);
                else if (pick < 17)
                    send_frame(FR_CUT);
                else if (pick == 17)
                    send_frame(FR_EDGE);
                else
                    repeat ($urandom_range(1, 4))
                        send_byte(rand_byte(), $urandom_range(0, 3) == 0);
            end
            push <= 1'b0;
        end

        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0d results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
